// File: sv/lfk_pkg.sv
package lfk_pkg;

  localparam int SineTableDepth = 1024;
  localparam int PhaseW = $clog2(4 * SineTableDepth);
  localparam int RemW = $clog2(SineTableDepth);
  localparam int IdxW = RemW + 1;
  localparam int SineBlocks = SineTableDepth / 32;
  localparam logic [18:0] PhaseK = 19'd333772;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgThighLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCalfLength = 1'b1;

  typedef logic signed [16:0] trig_t;
  typedef logic signed [31:0] vec_t;
  typedef logic [SineTableDepth:0][16:0] sine_tab_t;

  // Quarter-wave sine in Q15, built once by an integer Taylor series.
  // Entries near a quarter turn round up to a full 32768.
  function automatic sine_tab_t sine_table();
    sine_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint q15;
    int i;
    tab = '0;
    for (int hi = 0; hi <= SineBlocks; hi++) begin
      for (int lo = 0; lo < 32; lo++) begin
        i = hi * 32 + lo;
        if (i <= SineTableDepth) begin
          x = (64'(i) * 64'd3373259426 + 64'(SineTableDepth)) >> (RemW + 1);
          x2 = (x * x) >> 30;
          term = x;
          sum = longint'(x);
          for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
              sum = sum - longint'(term);
            end else begin
              sum = sum + longint'(term);
            end
          end
          if (sum < 0) begin
            sum = 0;
          end
          q15 = (sum + 64'sd16384) >>> 15;
          if (q15 > 32768) begin
            q15 = 32768;
          end
          tab[i] = q15[16:0];
        end
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTable = sine_table();

  // Sine at a phase, quadrant folded onto the quarter table.
  function automatic trig_t sine_at(input logic [PhaseW-1:0] ph);
    logic [1:0] quad;
    logic [RemW-1:0] r;
    logic [IdxW-1:0] idx;
    logic [16:0] mag;
    quad = ph[PhaseW-1 -: 2];
    r = ph[RemW-1:0];
    idx = quad[0] ? IdxW'(SineTableDepth) - IdxW'(r) : IdxW'(r);
    mag = SineTable[idx];
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  // Round half up from Q31 sums back to Q16.
  function automatic vec_t rnd15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v + 48'sd16384) >>> 15;
    return t[31:0];
  endfunction

  function automatic logic [17:0] sat18(input vec_t v);
    if (v > 32'sd131071) begin
      return 18'h1FFFF;
    end else if (v < -32'sd131072) begin
      return 18'h20000;
    end
    return v[17:0];
  endfunction

endpackage

// File: sv/leg_forward_kinematics.sv
// Foot position of a leg relative to the hip from four joint angles. The block
// is a six-stage pipeline (phase, table lookup, knee vector, yaw, roll, pitch
// with saturation) and takes one request per clock while the output side is
// not stalled. A stall holds every stage. The link lengths must be written
// while the block is idle.
module leg_forward_kinematics import lfk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_hip_pitch_angle,
  input  logic signed [15:0] in_hip_roll_angle,
  input  logic signed [15:0] in_hip_yaw_angle,
  input  logic signed [15:0] in_knee_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_foot_x,
  output logic signed [17:0] out_foot_y,
  output logic signed [17:0] out_foot_z,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int Stages = 6;

  logic [15:0] thigh_r;
  logic [15:0] calf_r;
  logic [Stages-1:0] vld_r;
  logic adv;

  logic [PhaseW-1:0] ph_r [4];
  trig_t sin_r [4];
  trig_t cos_r [4];
  trig_t sa2_r, ca2_r, sb2_r, cb2_r, sc2_r, cc2_r;
  trig_t sa3_r, ca3_r, sb3_r, cb3_r;
  trig_t sa4_r, ca4_r;
  vec_t vx_r, vz_r, vz4_r;
  vec_t x1_r, y1_r, x15_r;
  vec_t y2_r, z2_r;
  vec_t px_r, pz_r, y26_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thigh_r <= '0;
      calf_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgThighLength: thigh_r <= cfg_data;
        CfgCalfLength: calf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipe advances unless a finished result is held.
  assign adv = !vld_r[Stages-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[Stages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Stages-2:0], in_valid};
    end
  end

  // Stage 1: angle to table phase (rounded multiply by depth/(2*pi) scale).
  logic signed [15:0] ang [4];
  assign ang[0] = in_hip_pitch_angle;
  assign ang[1] = in_hip_roll_angle;
  assign ang[2] = in_hip_yaw_angle;
  assign ang[3] = in_knee_angle;

  for (genvar g = 0; g < 4; g++) begin : g_ph
    logic signed [47:0] prod;
    logic signed [47:0] sh;
    assign prod = 48'(ang[g]) * 48'(PhaseK) * 48'(SineTableDepth) + 48'sd2147483648;
    assign sh = prod >>> 32;
    always_ff @(posedge clk) begin
      if (adv) begin
        ph_r[g] <= sh[PhaseW-1:0];
      end
    end
    // Stage 2: sine and cosine lookup.
    always_ff @(posedge clk) begin
      if (adv) begin
        sin_r[g] <= sine_at(ph_r[g]);
        cos_r[g] <= sine_at(ph_r[g] + PhaseW'(SineTableDepth));
      end
    end
  end

  // Stage 3: knee vector in the thigh frame.
  logic signed [47:0] vx_s, vz_s;
  always_comb begin
    vx_s = -(48'($signed({1'b0, calf_r})) * 48'(sin_r[3]));
    vz_s = -(48'($signed({1'b0, thigh_r})) * 48'sd32768)
           - 48'($signed({1'b0, calf_r})) * 48'(cos_r[3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r <= rnd15(vx_s);
      vz_r <= rnd15(vz_s);
      sa2_r <= sin_r[0];
      ca2_r <= cos_r[0];
      sb2_r <= sin_r[1];
      cb2_r <= cos_r[1];
      sc2_r <= sin_r[2];
      cc2_r <= cos_r[2];
    end
  end

  // Stage 4: yaw, with zero y input.
  lfk_rot u_yaw (
    .clk(clk), .en(adv), .c(cc2_r), .s(sc2_r), .u(vx_r), .w('0),
    .a_r(x1_r), .b_r(y1_r)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      vz4_r <= vz_r;
      sa3_r <= sa2_r;
      ca3_r <= ca2_r;
      sb3_r <= sb2_r;
      cb3_r <= cb2_r;
    end
  end

  // Stage 5: roll acting on (y1, vz).
  lfk_rot u_roll (
    .clk(clk), .en(adv), .c(cb3_r), .s(sb3_r), .u(y1_r), .w(vz4_r),
    .a_r(y2_r), .b_r(z2_r)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      x15_r <= x1_r;
      sa4_r <= sa3_r;
      ca4_r <= ca3_r;
    end
  end

  // Stage 6: pitch acting on (z2, x1): pz = c*z2 - s*x1, px = s*z2 + c*x1.
  lfk_rot u_pitch (
    .clk(clk), .en(adv), .c(ca4_r), .s(sa4_r), .u(z2_r), .w(x15_r),
    .a_r(pz_r), .b_r(px_r)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      y26_r <= y2_r;
    end
  end

  assign out_foot_x = sat18(px_r);
  assign out_foot_y = sat18(y26_r);
  assign out_foot_z = sat18(pz_r);

endmodule

// File: sv/lfk_rot.sv
// One plane rotation stage: a = c*u - s*w and b = s*u + c*w, rounded, registered.
module lfk_rot import lfk_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  trig_t c,
  input  trig_t s,
  input  vec_t  u,
  input  vec_t  w,
  output vec_t  a_r,
  output vec_t  b_r
);

  logic signed [47:0] a_nxt;
  logic signed [47:0] b_nxt;

  // Products are summed at full width, then rounded once.
  always_comb begin
    a_nxt = 48'(c) * 48'(u) - 48'(s) * 48'(w);
    b_nxt = 48'(s) * 48'(u) + 48'(c) * 48'(w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= rnd15(a_nxt);
      b_r <= rnd15(b_nxt);
    end
  end

endmodule

// File: sv/lfk_checker.sv
module leg_forward_kinematics_sva import lfk_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] out_foot_x,
  input logic signed [17:0] out_foot_y,
  input logic signed [17:0] out_foot_z
);

  // A held result keeps its position.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_foot_x)
      && $stable(out_foot_y) && $stable(out_foot_z))
    else $error("held result changed");

  // The input side stalls only when the output is blocked.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // With no stalls, an accepted request reaches the output after passing every pipeline stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind leg_forward_kinematics leg_forward_kinematics_sva u_lfk_checker (.*);
